// ===== hw/rtl/pileup_mutation_site_summarizer_unit_defines.svh =====
// Assertion macros for the pileup mutation site summarizer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef PILEUP_MUTATION_SITE_SUMMARIZER_UNIT_DEFINES_SVH
`define PILEUP_MUTATION_SITE_SUMMARIZER_UNIT_DEFINES_SVH

`define PMSS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmss assertion failed");

`define PMSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmss assertion failed");

`endif

// ===== hw/rtl/pmss_pkg.sv =====
// Package for the pileup mutation site summarizer: sizes, item types,
// state and metric codes, and controller to datapath command and status types.
package pmss_pkg;

  localparam int MAX_SAMPLES = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int NUM_BASES   = 4;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES * NUM_BASES);
  localparam int SAMPLE_W    = ADDR_W - 2;
  localparam int ACC_W       = COUNT_WIDTH + ADDR_W;
  localparam int FRAC_W      = 16;
  localparam int VAL_W       = 32;
  localparam int DIV_W       = ACC_W + FRAC_W;
  localparam int DCNT_W      = $clog2(DIV_W + 1);
  localparam int NS_W        = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int QUAL_OFFSET = 33;

  localparam logic [7:0]      RST_MIN_MQ = 8'd13;
  localparam logic [7:0]      RST_MIN_BQ = 8'd46;
  localparam logic [NS_W-1:0] RST_NUM_SAMPLES = 5'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_MQ,
    CFG_MIN_BQ,
    CFG_NUM_SAMPLES
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MET_MUT_BASE,
    MET_MUT_SAMPLE,
    MET_MUT_FRAC,
    MET_WT_FRAC,
    MET_MUT_FWD,
    MET_MUT_REV,
    MET_WT_REF_FWD,
    MET_WT_REF_REV,
    MET_MUT_BQ,
    MET_MUT_OTH_BQ,
    MET_WT_BQ,
    MET_MUT_MQ,
    MET_MUT_OTH_MQ,
    MET_WT_MQ,
    MET_MUT_DEPTH
  } metric_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OBS_RD,
    ST_OBS_WR,
    ST_SCAN1,
    ST_DRAIN1,
    ST_DECIDE,
    ST_SCAN2,
    ST_DRAIN2,
    ST_MET_SEL,
    ST_MET_DIV,
    ST_MET_OUT
  } state_e;

  typedef struct packed {
    logic       req_type;
    logic [3:0] sample_index;
    logic [2:0] base;
    logic [7:0] base_quality_char;
    logic [7:0] map_quality;
    logic       reverse_strand;
    logic [1:0] reference_base;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  metric_code;
    logic [31:0] metric_value;
    logic        undefined;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] fwd;
    logic [COUNT_WIDTH-1:0] rev;
    logic [COUNT_WIDTH-1:0] mq;
    logic [COUNT_WIDTH-1:0] bq;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic obs_rd;
    logic obs_wr;
    logic scan_init;
    logic scan;
    logic pass2;
    logic decide;
    logic div_start;
    logic met_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic no_mut;
    logic need_div;
    logic div_done;
    logic last_metric;
  } status_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                     input logic [COUNT_WIDTH-1:0] b);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
  endfunction

endpackage

// ===== hw/rtl/pileup_mutation_site_summarizer_unit.sv =====
// Pileup mutation site summarizer, top level. Depends on pmss_pkg, pmss_ctrl,
// pmss_datapath and the assertion macros header.
// An observation item holds busy_o high while it reads and updates its entry.
// A summarize item scans the store (4 reads per sample in use), again if one mutant
// base is found, then emits 15 results; nonzero denominators go through the divider.
// Reset restores the registers to 13, 46 and 2 and empties the store at once.
`include "pileup_mutation_site_summarizer_unit_defines.svh"

module pileup_mutation_site_summarizer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  pmss_pkg::in_t                   item_i,
  input  logic                            cfg_we_i,
  input  logic [pmss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pmss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic                            result_valid_o,
  output pmss_pkg::out_t                  result_o
);
  import pmss_pkg::*;

  cmd_t    cmd;
  status_t status;

  pmss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .req_type_i     (item_i.req_type),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  pmss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

  `PMSS_ASSERT_SAME(a_result_while_busy, result_valid_o, busy_o)
  `PMSS_ASSERT_SAME(a_last_on_final_code, result_valid_o && result_o.last,
                    result_o.metric_code == 4'(MET_MUT_DEPTH))
  `PMSS_ASSERT_NEXT(a_idle_after_last, result_valid_o && result_o.last, !busy_o)
  `PMSS_ASSERT_NEXT(a_busy_after_accept, start_i && !busy_o, busy_o)

endmodule

// ===== hw/rtl/pmss_div.sv =====
// Restoring divider, one quotient bit per cycle, for the metric ratios.
// Depends on pmss_pkg.
module pmss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pmss_pkg::ACC_W-1:0] num_i,
  input  logic [pmss_pkg::ACC_W-1:0] den_i,
  output logic                       done_o,
  output logic [pmss_pkg::DIV_W-1:0] quo_o
);
  import pmss_pkg::*;

  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0]  rem_q, rem_d;
  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [ACC_W-1:0]  den_q, den_d;
  logic [ACC_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvd_d = dvd_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = DCNT_W'(DIV_W);
      rem_d = '0;
      dvd_d = {num_i, {FRAC_W{1'b0}}};
      den_d = den_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = fits ? ACC_W'(trial - {1'b0, den_q}) : trial[ACC_W-1:0];
      dvd_d = {dvd_q[DIV_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    den_q <= den_d;
  end

  assign done_o = cnt_q == DCNT_W'(1);
  assign quo_o  = dvd_q;

endmodule

// ===== hw/rtl/pmss_datapath.sv =====
// Datapath: configuration registers, counter store, genotype scan,
// metric accumulators and result formatting. Depends on pmss_pkg and pmss_div.
module pmss_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pmss_pkg::in_t                   item_i,
  input  logic                            cfg_we_i,
  input  logic [pmss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pmss_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  pmss_pkg::cmd_t                  cmd_i,
  output pmss_pkg::status_t               status_o,
  output pmss_pkg::out_t                  result_o
);
  import pmss_pkg::*;

  logic [7:0]      min_mq_q, min_bq_q;
  logic [NS_W-1:0] num_samples_q, n_eff;
  in_t             item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mq_q      <= RST_MIN_MQ;
      min_bq_q      <= RST_MIN_BQ;
      num_samples_q <= RST_NUM_SAMPLES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_MQ:      min_mq_q <= cfg_wdata_i;
        CFG_MIN_BQ:      min_bq_q <= cfg_wdata_i;
        CFG_NUM_SAMPLES: num_samples_q <= cfg_wdata_i[NS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (num_samples_q == '0) begin
      n_eff = NS_W'(1);
    end else if (int'(num_samples_q) > MAX_SAMPLES) begin
      n_eff = NS_W'(MAX_SAMPLES);
    end else begin
      n_eff = num_samples_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // Counter store with one valid bit per entry; an invalid entry reads as zero.
  entry_t            mem_q [MAX_SAMPLES*NUM_BASES];
  entry_t            rd_data_q, cur, upd;
  logic              rd_vld_q;
  logic [MAX_SAMPLES*NUM_BASES-1:0] valid_q;
  logic [ADDR_W-1:0] obs_addr, scan_addr_q, rd_addr, last_addr;
  logic              rd_en, keep;
  logic [7:0]        bq_term;

  assign obs_addr  = ADDR_W'({item_q.sample_index, item_q.base[1:0]});
  assign rd_addr   = cmd_i.obs_rd ? obs_addr : scan_addr_q;
  assign rd_en     = cmd_i.obs_rd | cmd_i.scan;
  assign last_addr = ADDR_W'({n_eff, 2'b00} - 7'd1);
  assign cur       = rd_vld_q ? rd_data_q : '0;

  assign keep = (item_q.map_quality > min_mq_q) && (item_q.base_quality_char > min_bq_q) &&
                (item_q.base < 3'd4) && ({1'b0, item_q.sample_index} < n_eff);
  assign bq_term = (item_q.base_quality_char >= 8'(QUAL_OFFSET)) ?
                   item_q.base_quality_char - 8'(QUAL_OFFSET) : 8'd0;

  always_comb begin
    upd     = cur;
    upd.bq  = sat_add(cur.bq, COUNT_WIDTH'(bq_term));
    upd.mq  = sat_add(cur.mq, COUNT_WIDTH'(item_q.map_quality));
    if (item_q.reverse_strand) begin
      upd.rev = sat_add(cur.rev, COUNT_WIDTH'(1));
    end else begin
      upd.fwd = sat_add(cur.fwd, COUNT_WIDTH'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.obs_wr && keep) begin
      mem_q[obs_addr] <= upd;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  logic              pipe_v_q, pipe_pass2_q;
  logic [ADDR_W-1:0] pipe_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      scan_addr_q <= '0;
      pipe_v_q    <= 1'b0;
      pipe_pass2_q <= 1'b0;
      pipe_addr_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        valid_q <= '0;
      end else if (cmd_i.obs_wr && keep) begin
        valid_q[obs_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
      if (cmd_i.scan_init) begin
        scan_addr_q <= '0;
      end else if (cmd_i.scan) begin
        scan_addr_q <= scan_addr_q + 1'b1;
      end
      pipe_v_q     <= cmd_i.scan;
      pipe_pass2_q <= cmd_i.pass2;
      pipe_addr_q  <= scan_addr_q;
    end
  end

  // Genotype scan: running argmax over the four bases of each sample.
  logic [1:0]             p_b, bb_q, prev_bb, nbb;
  logic [SAMPLE_W-1:0]    p_s;
  logic [COUNT_WIDTH-1:0] p_ar, best_q, prev_best, nbest;
  logic                   any_q, nany, win;
  logic [1:0]             freq_q  [NUM_BASES];
  logic [SAMPLE_W-1:0]    first_q [NUM_BASES];

  assign p_b       = pipe_addr_q[1:0];
  assign p_s       = pipe_addr_q[ADDR_W-1:2];
  assign p_ar      = sat_add(cur.fwd, cur.rev);
  assign prev_best = (p_b == 2'd0) ? '0 : best_q;
  assign prev_bb   = (p_b == 2'd0) ? 2'd0 : bb_q;
  assign win       = p_ar > prev_best;
  assign nbest     = win ? p_ar : prev_best;
  assign nbb       = win ? p_b : prev_bb;
  assign nany      = ((p_b == 2'd0) ? 1'b0 : any_q) | (p_ar != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= '{default: '0};
      any_q  <= 1'b0;
      bb_q   <= '0;
    end else if (cmd_i.scan_init && !cmd_i.decide) begin
      freq_q <= '{default: '0};
    end else if (pipe_v_q && !pipe_pass2_q) begin
      any_q <= nany;
      bb_q  <= nbb;
      if (p_b == 2'd3 && nany) begin
        if (freq_q[nbb] != 2'd2) begin
          freq_q[nbb] <= freq_q[nbb] + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_v_q && !pipe_pass2_q) begin
      best_q <= nbest;
      if (p_b == 2'd3 && nany && freq_q[nbb] == 2'd0) begin
        first_q[nbb] <= p_s;
      end
    end
  end

  logic [2:0]          n_mut;
  logic [1:0]          mb_c, mb_q;
  logic [SAMPLE_W-1:0] ms_q;
  logic                no_mut_q;

  always_comb begin
    n_mut = '0;
    mb_c  = '0;
    for (int b = 0; b < NUM_BASES; b++) begin
      if (freq_q[b] == 2'd1) begin
        n_mut = n_mut + 3'd1;
        mb_c  = 2'(b);
      end
    end
  end

  // Metric sums over the mutant sample and the other samples.
  logic [COUNT_WIDTH-1:0] m_f_q, m_r_q, m_bq_q, m_mq_q, m_ar_q;
  logic [ACC_W-1:0] depth_m_q, oth_mq_q, oth_bq_q, qden_q;
  logic [ACC_W-1:0] nm_wt_q, f_wt_q, r_wt_q, wmq_q, wbq_q, wdepth_q;
  logic             p_is_ms;
  metric_e          metric_q;

  assign p_is_ms = p_s == ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_mut_q <= 1'b1;
      metric_q <= MET_MUT_BASE;
    end else if (cmd_i.decide) begin
      no_mut_q <= n_mut != 3'd1;
      metric_q <= MET_MUT_BASE;
    end else if (cmd_i.met_next) begin
      metric_q <= metric_e'(metric_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      mb_q      <= mb_c;
      ms_q      <= first_q[mb_c];
      m_f_q     <= '0;
      m_r_q     <= '0;
      m_bq_q    <= '0;
      m_mq_q    <= '0;
      m_ar_q    <= '0;
      depth_m_q <= '0;
      oth_mq_q  <= '0;
      oth_bq_q  <= '0;
      qden_q    <= '0;
      nm_wt_q   <= '0;
      f_wt_q    <= '0;
      r_wt_q    <= '0;
      wmq_q     <= '0;
      wbq_q     <= '0;
      wdepth_q  <= '0;
    end else if (pipe_v_q && pipe_pass2_q) begin
      if (p_is_ms) begin
        depth_m_q <= depth_m_q + ACC_W'(p_ar);
        if (p_b == mb_q) begin
          m_f_q  <= cur.fwd;
          m_r_q  <= cur.rev;
          m_bq_q <= cur.bq;
          m_mq_q <= cur.mq;
          m_ar_q <= p_ar;
        end else begin
          oth_mq_q <= oth_mq_q + ACC_W'(cur.mq);
          oth_bq_q <= oth_bq_q + ACC_W'(cur.bq);
          qden_q   <= qden_q + ACC_W'(p_ar);
        end
      end else begin
        if (p_b == mb_q) begin
          nm_wt_q <= nm_wt_q + ACC_W'(p_ar);
        end
        if (p_b == item_q.reference_base) begin
          f_wt_q <= f_wt_q + ACC_W'(cur.fwd);
          r_wt_q <= r_wt_q + ACC_W'(cur.rev);
        end
        wmq_q    <= wmq_q + ACC_W'(cur.mq);
        wbq_q    <= wbq_q + ACC_W'(cur.bq);
        wdepth_q <= wdepth_q + ACC_W'(p_ar);
      end
    end
  end

  logic             is_ratio;
  logic [ACC_W-1:0] num, den, cnt_val;

  always_comb begin
    is_ratio = 1'b1;
    num      = '0;
    den      = '0;
    cnt_val  = '0;
    unique case (metric_q)
      MET_MUT_BASE:   begin is_ratio = 1'b0; cnt_val = ACC_W'(mb_q); end
      MET_MUT_SAMPLE: begin is_ratio = 1'b0; cnt_val = ACC_W'(ms_q); end
      MET_MUT_FRAC:   begin num = ACC_W'(m_ar_q); den = depth_m_q; end
      MET_WT_FRAC:    begin num = nm_wt_q; den = wdepth_q; end
      MET_MUT_FWD:    begin is_ratio = 1'b0; cnt_val = ACC_W'(m_f_q); end
      MET_MUT_REV:    begin is_ratio = 1'b0; cnt_val = ACC_W'(m_r_q); end
      MET_WT_REF_FWD: begin is_ratio = 1'b0; cnt_val = f_wt_q; end
      MET_WT_REF_REV: begin is_ratio = 1'b0; cnt_val = r_wt_q; end
      MET_MUT_BQ:     begin num = ACC_W'(m_bq_q); den = ACC_W'(m_ar_q); end
      MET_MUT_OTH_BQ: begin num = oth_bq_q; den = qden_q; end
      MET_WT_BQ:      begin num = wbq_q; den = wdepth_q; end
      MET_MUT_MQ:     begin num = ACC_W'(m_mq_q); den = ACC_W'(m_ar_q); end
      MET_MUT_OTH_MQ: begin num = oth_mq_q; den = qden_q; end
      MET_WT_MQ:      begin num = wmq_q; den = wdepth_q; end
      MET_MUT_DEPTH:  begin is_ratio = 1'b0; cnt_val = depth_m_q; end
      default:        begin is_ratio = 1'b0; end
    endcase
  end

  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic [VAL_W-1:0] quo_sat, cnt_fix;

  pmss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign quo_sat = (|quo[DIV_W-1:VAL_W]) ? '1 : quo[VAL_W-1:0];
  assign cnt_fix = (|cnt_val[ACC_W-1:VAL_W-FRAC_W]) ? '1 :
                   {cnt_val[VAL_W-FRAC_W-1:0], {FRAC_W{1'b0}}};

  always_comb begin
    result_o.status      = no_mut_q;
    result_o.metric_code = metric_q;
    result_o.last        = metric_q == MET_MUT_DEPTH;
    result_o.undefined   = !no_mut_q && is_ratio && (den == '0);
    if (no_mut_q || (is_ratio && den == '0)) begin
      result_o.metric_value = '0;
    end else if (is_ratio) begin
      result_o.metric_value = quo_sat;
    end else begin
      result_o.metric_value = cnt_fix;
    end
  end

  assign status_o.scan_last   = scan_addr_q == last_addr;
  assign status_o.no_mut      = n_mut != 3'd1;
  assign status_o.need_div    = !no_mut_q && is_ratio && (den != '0);
  assign status_o.div_done    = div_done;
  assign status_o.last_metric = metric_q == MET_MUT_DEPTH;

endmodule

// ===== hw/rtl/pmss_ctrl.sv =====
// Controller state machine: sequences observation updates, the two store
// scans, the divider and result output. Depends on pmss_pkg.
module pmss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              req_type_i,
  input  pmss_pkg::status_t status_i,
  output pmss_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              result_valid_o
);
  import pmss_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = req_type_i ? ST_SCAN1 : ST_OBS_RD;
        end
      end
      ST_OBS_RD:  state_d = ST_OBS_WR;
      ST_OBS_WR:  state_d = ST_IDLE;
      ST_SCAN1:   if (status_i.scan_last) state_d = ST_DRAIN1;
      ST_DRAIN1:  state_d = ST_DECIDE;
      ST_DECIDE:  state_d = status_i.no_mut ? ST_MET_SEL : ST_SCAN2;
      ST_SCAN2:   if (status_i.scan_last) state_d = ST_DRAIN2;
      ST_DRAIN2:  state_d = ST_MET_SEL;
      ST_MET_SEL: state_d = status_i.need_div ? ST_MET_DIV : ST_MET_OUT;
      ST_MET_DIV: if (status_i.div_done) state_d = ST_MET_OUT;
      ST_MET_OUT: state_d = status_i.last_metric ? ST_IDLE : ST_MET_SEL;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o          = 1'b0;
        cmd_o.load_item = start_i;
        cmd_o.scan_init = start_i;
      end
      ST_OBS_RD:  cmd_o.obs_rd = 1'b1;
      ST_OBS_WR:  cmd_o.obs_wr = 1'b1;
      ST_SCAN1:   cmd_o.scan = 1'b1;
      ST_DRAIN1:  ;
      ST_DECIDE: begin
        cmd_o.decide    = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      ST_SCAN2: begin
        cmd_o.scan  = 1'b1;
        cmd_o.pass2 = 1'b1;
      end
      ST_DRAIN2:  ;
      ST_MET_SEL: cmd_o.div_start = status_i.need_div;
      ST_MET_DIV: ;
      ST_MET_OUT: begin
        result_valid_o = 1'b1;
        cmd_o.met_next = !status_i.last_metric;
        cmd_o.clear    = status_i.last_metric;
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/tb_pileup_mutation_site_summarizer_unit.sv =====
// Self-checking testbench for pileup_mutation_site_summarizer_unit.
// Depends on pmss_pkg; a built-in predictor tracks the counter store and
// configuration and checks every summary result against it.
module tb_pileup_mutation_site_summarizer_unit;
  import pmss_pkg::*;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_e;

  typedef struct {
    op_kind_e kind;
    in_t      item;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    bit       calm;
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam int QUIET_CYCLES = 8;

  logic  clk_i, rst_ni, start_i, busy_o, cfg_we_i, result_valid_o;
  in_t   item_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  out_t  result_o;

  op_t   pending_ops[$];
  out_t  expected_metrics[$];
  int    errors = 0;

  logic [15:0] fwd_cnt [64];
  logic [15:0] rev_cnt [64];
  logic [15:0] mq_sum [64];
  logic [15:0] bq_sum [64];
  logic [7:0]  min_mq = RST_MIN_MQ;
  logic [7:0]  min_bq = RST_MIN_BQ;
  logic [4:0]  nsamp  = RST_NUM_SAMPLES;

  pileup_mutation_site_summarizer_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #40_000_000;
    $display("tb_pileup_mutation_site_summarizer_unit: FAIL");
    $finish;
  end

  function automatic logic [15:0] sat16(input longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic longint unsigned reads_of(input int s, input int b);
    return sat16(fwd_cnt[s*4+b] + rev_cnt[s*4+b]);
  endfunction

  function automatic void clear_counts();
    for (int i = 0; i < 64; i++) begin
      fwd_cnt[i] = '0; rev_cnt[i] = '0; mq_sum[i] = '0; bq_sum[i] = '0;
    end
  endfunction

  function automatic void push_metric(input logic st, input int k, input longint unsigned val,
                                      input logic undef);
    out_t r;
    r.status       = st;
    r.metric_code  = metric_e'(k);
    r.metric_value = val[31:0];
    r.undefined    = undef;
    r.last         = (k == 14);
    expected_metrics = {expected_metrics, r};
  endfunction

  function automatic longint unsigned fixed_count(input longint unsigned v);
    return (v > 64'hFFFF) ? 64'hFFFF_FFFF : (v << 16);
  endfunction

  function automatic void push_ratio(input int k, input longint unsigned num,
                                     input longint unsigned den);
    longint unsigned q;
    if (den == 0) begin
      push_metric(1'b0, k, 0, 1'b1);
    end else begin
      q = (num << 16) / den;
      push_metric(1'b0, k, (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q, 1'b0);
    end
  endfunction

  function automatic void predict_site(input in_t it);
    int n, idx, ms, mb, n_mut;
    int geno[16];
    bit has[16];
    int freq[4];
    longint unsigned best, a, dm, omq, obq, qden, nm, fw, rw, wmq, wbq, wd;
    n = (nsamp == 0) ? 1 : (nsamp > 16) ? 16 : nsamp;
    if (it.req_type == 1'b0) begin
      if (it.map_quality <= min_mq || it.base_quality_char <= min_bq) return;
      if (it.base >= 4 || it.sample_index >= n) return;
      idx = it.sample_index * 4 + it.base;
      bq_sum[idx] = sat16(bq_sum[idx] +
                          ((it.base_quality_char >= QUAL_OFFSET) ?
                           it.base_quality_char - QUAL_OFFSET : 0));
      mq_sum[idx] = sat16(mq_sum[idx] + it.map_quality);
      if (it.reverse_strand) rev_cnt[idx] = sat16(rev_cnt[idx] + 1);
      else fwd_cnt[idx] = sat16(fwd_cnt[idx] + 1);
      return;
    end
    freq = '{0, 0, 0, 0};
    for (int s = 0; s < n; s++) begin
      best = 0; geno[s] = 0; has[s] = 0;
      for (int b = 0; b < 4; b++) begin
        a = reads_of(s, b);
        if (a != 0) has[s] = 1;
        if (a > best) begin best = a; geno[s] = b; end
      end
      if (has[s]) freq[geno[s]]++;
    end
    n_mut = 0; mb = 0; ms = 0;
    for (int b = 0; b < 4; b++) if (freq[b] == 1) begin n_mut++; mb = b; end
    if (n_mut != 1) begin
      for (int k = 0; k < 15; k++) push_metric(1'b1, k, 0, 1'b0);
      clear_counts();
      return;
    end
    for (int s = n - 1; s >= 0; s--) if (has[s] && geno[s] == mb) ms = s;
    dm = 0; omq = 0; obq = 0; qden = 0; nm = 0; fw = 0; rw = 0; wmq = 0; wbq = 0; wd = 0;
    for (int b = 0; b < 4; b++) begin
      dm += reads_of(ms, b);
      if (b != mb) begin
        omq += mq_sum[ms*4+b]; obq += bq_sum[ms*4+b]; qden += reads_of(ms, b);
      end
    end
    for (int s = 0; s < n; s++) begin
      if (s != ms) begin
        nm += reads_of(s, mb);
        fw += fwd_cnt[s*4+it.reference_base];
        rw += rev_cnt[s*4+it.reference_base];
        for (int b = 0; b < 4; b++) begin
          wmq += mq_sum[s*4+b]; wbq += bq_sum[s*4+b]; wd += reads_of(s, b);
        end
      end
    end
    push_metric(1'b0, 0, fixed_count(mb), 1'b0);
    push_metric(1'b0, 1, fixed_count(ms), 1'b0);
    push_ratio(2, reads_of(ms, mb), dm);
    push_ratio(3, nm, wd);
    push_metric(1'b0, 4, fixed_count(fwd_cnt[ms*4+mb]), 1'b0);
    push_metric(1'b0, 5, fixed_count(rev_cnt[ms*4+mb]), 1'b0);
    push_metric(1'b0, 6, fixed_count(fw), 1'b0);
    push_metric(1'b0, 7, fixed_count(rw), 1'b0);
    push_ratio(8, bq_sum[ms*4+mb], reads_of(ms, mb));
    push_ratio(9, obq, qden);
    push_ratio(10, wbq, wd);
    push_ratio(11, mq_sum[ms*4+mb], reads_of(ms, mb));
    push_ratio(12, omq, qden);
    push_ratio(13, wmq, wd);
    push_metric(1'b0, 14, fixed_count(dm), 1'b0);
    clear_counts();
  endfunction

  // Driver: items wait for busy low; register writes wait for a quiet block.
  int  gap_left = 0;
  int  quiet = 0;
  bit  idle_on = 1;

  always @(posedge clk_i or negedge rst_ni) begin
    bit   nstart, nwe;
    in_t  nitem;
    logic [CFG_IDX_W-1:0]  nidx;
    logic [CFG_DATA_W-1:0] ndata;
    op_t  op;
    if (!rst_ni) begin
      start_i <= 1'b0; item_i <= '0; cfg_we_i <= 1'b0; cfg_idx_i <= '0; cfg_wdata_i <= '0;
    end else begin
      nstart = start_i; nitem = item_i; nwe = 1'b0; nidx = cfg_idx_i; ndata = cfg_wdata_i;
      if (start_i && !busy_o) begin
        predict_site(item_i);
        nstart = 1'b0;
      end
      if (busy_o || start_i || cfg_we_i || expected_metrics.size() != 0) quiet = 0;
      else quiet++;
      if (!nstart) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0) begin
          op = pending_ops[0];
          if (op.kind == OP_ITEM) begin
            void'(pending_ops.pop_front());
            nstart = 1'b1; nitem = op.item;
            idle_on = !op.calm;
            if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
          end else if (quiet >= QUIET_CYCLES) begin
            void'(pending_ops.pop_front());
            if (op.kind == OP_CFG) begin
              nwe = 1'b1; nidx = op.idx; ndata = op.data;
              case (op.idx)
                CFG_MIN_MQ:      min_mq = op.data;
                CFG_MIN_BQ:      min_bq = op.data;
                CFG_NUM_SAMPLES: nsamp  = op.data[4:0];
                default: ;
              endcase
            end
          end
        end
      end
      start_i <= nstart; item_i <= nitem;
      cfg_we_i <= nwe; cfg_idx_i <= nidx; cfg_wdata_i <= ndata;
    end
  end

  // Monitor: every strobed result is checked against the oldest expected metric.
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_metrics.size() == 0) begin
        $error("unexpected result: code %0d value %h", result_o.metric_code,
               result_o.metric_value);
        errors++;
      end else begin
        e = expected_metrics.pop_front();
        if (result_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, result_o.status); errors++;
        end
        if (result_o.metric_code !== e.metric_code) begin
          $error("metric_code: expected %0d, got %0d", e.metric_code, result_o.metric_code);
          errors++;
        end
        if (result_o.metric_value !== e.metric_value) begin
          $error("metric_value: expected %h, got %h", e.metric_value, result_o.metric_value);
          errors++;
        end
        if (result_o.undefined !== e.undefined) begin
          $error("undefined: expected %0d, got %0d", e.undefined, result_o.undefined);
          errors++;
        end
        if (result_o.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, result_o.last); errors++;
        end
      end
    end
  end

  function automatic void add_obs(input int s, input int b, input int q, input int mq,
                                  input bit rev, input bit calm = 0);
    op_t op;
    op.kind = OP_ITEM; op.calm = calm; op.idx = '0; op.data = '0;
    op.item = '{req_type: 1'b0, sample_index: s[3:0], base: b[2:0],
                base_quality_char: q[7:0], map_quality: mq[7:0], reverse_strand: rev,
                reference_base: 2'($urandom_range(0, 3))};
    pending_ops = {pending_ops, op};
  endfunction

  function automatic void add_summary(input int refb, input bit calm = 0);
    op_t op;
    op.kind = OP_ITEM; op.calm = calm; op.idx = '0; op.data = '0;
    op.item = in_t'($urandom());
    op.item.req_type = 1'b1;
    op.item.reference_base = refb[1:0];
    pending_ops = {pending_ops, op};
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input int data);
    op_t op;
    op.kind = OP_CFG; op.calm = 0; op.item = '0; op.idx = idx; op.data = data[7:0];
    pending_ops = {pending_ops, op};
  endfunction

  function automatic void add_drain();
    op_t op;
    op.kind = OP_DRAIN; op.calm = 0; op.item = '0; op.idx = '0; op.data = '0;
    pending_ops = {pending_ops, op};
  endfunction

  function automatic void add_random_site(input bit calm);
    int n, ms, mb, refb, cnt, s, b;
    n = (nsamp == 0) ? 1 : (nsamp > 16) ? 16 : nsamp;
    ms = $urandom_range(0, n - 1);
    mb = $urandom_range(0, 3);
    refb = $urandom_range(0, 3);
    cnt = $urandom_range(1, 6);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 4) != 0) begin
        s = $urandom_range(0, n - 1);
        b = (s == ms && $urandom_range(0, 3) != 0) ? mb : refb;
        add_obs(s, b, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1),
                calm);
      end else begin
        add_obs($urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 255),
                $urandom_range(0, 255), $urandom_range(0, 1), calm);
      end
    end
    add_summary(refb, calm);
  endfunction

  initial begin
    int site_cfg;
    clear_counts();

    // Directed: a lone sample with reads, filtered items, an empty site.
    add_obs(1, 1, 255, 255, 1);
    add_obs(1, 1, 47, 14, 0);
    add_obs(1, 0, 80, 60, 0);
    add_obs(0, 2, 80, 13, 0);
    add_obs(0, 2, 46, 200, 0);
    add_obs(0, 4, 90, 90, 0);
    add_obs(0, 7, 90, 90, 1);
    add_obs(2, 3, 90, 90, 0);
    add_obs(15, 0, 0, 0, 1);
    add_summary(1);
    add_summary(0);
    // Three samples, a tie inside the mutant sample, quality chars below 33.
    add_cfg(CFG_NUM_SAMPLES, 3);
    add_cfg(CFG_MIN_MQ, 0);
    add_cfg(CFG_MIN_BQ, 0);
    add_obs(0, 0, 10, 1, 0);
    add_obs(2, 0, 40, 30, 1);
    add_obs(1, 3, 20, 255, 0);
    add_obs(1, 1, 70, 5, 1);
    add_obs(0, 0, 255, 255, 1);
    add_summary(0);
    // Everything filtered, then an unused register index and a zero sample count.
    add_cfg(CFG_MIN_MQ, 255);
    add_cfg(CFG_MIN_BQ, 255);
    add_obs(0, 0, 255, 255, 0);
    add_summary(3);
    add_cfg(CFG_IDX_UNUSED, 8'hA5);
    add_cfg(CFG_MIN_MQ, 13);
    add_cfg(CFG_MIN_BQ, 46);
    add_cfg(CFG_NUM_SAMPLES, 0);
    add_obs(0, 3, 99, 99, 0);
    add_obs(1, 2, 99, 99, 0);
    add_summary(2);

    // Oversized sample count and sum saturation: many high-quality reads on one entry.
    add_cfg(CFG_NUM_SAMPLES, 8'hFF);
    add_obs(15, 1, 200, 200, 0);
    for (int i = 0; i < 258; i++) add_obs(4, 2, 255, 255, i % 2);
    add_obs(9, 0, 100, 100, 1);
    add_summary(0);

    // Random sites under a sequence of register settings.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 3 == 0) begin
        site_cfg = $urandom_range(0, 5);
        add_cfg(CFG_MIN_MQ, (site_cfg == 0) ? 0 : (site_cfg == 5) ? 255 :
                $urandom_range(0, 40));
        add_cfg(CFG_MIN_BQ, (site_cfg == 0) ? 0 : (site_cfg == 5) ? 255 :
                $urandom_range(30, 70));
        add_cfg(CFG_NUM_SAMPLES, (site_cfg == 1) ? 1 : (site_cfg == 2) ? 16 :
                $urandom_range(0, 255));
      end
      if (ph % 7 == 3) add_drain();
      add_random_site(ph >= 10);
    end

    wait (pending_ops.size() == 0 && !start_i && expected_metrics.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_metrics.size() == 0)
      $display("tb_pileup_mutation_site_summarizer_unit: PASS");
    else
      $display("tb_pileup_mutation_site_summarizer_unit: FAIL");
    $finish;
  end

endmodule
